>>> src/lca_pkg.sv
// Shared definitions for the lowest common ancestor block.
// Holds size defaults, transaction action codes and the sequencer state type.
// No dependencies.
`default_nettype none

package lca_pkg;

   localparam int MAX_NODES_DEF   = 1024;
   localparam int LIFT_LEVELS_DEF = 11;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BUILD = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_BD_RD1,
      ST_BD_RD2,
      ST_BD_WR,
      ST_QY_DA,
      ST_QY_DB,
      ST_QY_SW,
      ST_QY_LIFT,
      ST_QY_LIFTW,
      ST_QY_EQ,
      ST_QY_PAR,
      ST_QY_PARW,
      ST_QY_FIN,
      ST_QY_FINW,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

>>> src/tree_lowest_common_ancestor_top.sv
// Lowest common ancestor engine using binary lifting over an on-chip ancestor table.
// Depends on lca_pkg.
//
//  Channel | Ports                                                  | Direction
//  --------+--------------------------------------------------------+----------
//  request | req_valid, req_stall, req_action, req_child_node,      | in
//          | req_parent_node, req_node_a, req_node_b                |
//  response| rsp_valid, rsp_stall, rsp_ancestor, rsp_bad_index     | out
//  csr     | csr_we, csr_wdata (node count)                         | in
//
// A load does one depth memory read, then the write back.
// A build does two dependent table reads and a write for every node and level.
// A query reads both depths, lifts the deeper node to the shallower depth, then lifts both
// nodes together while their ancestors differ, over floor(log2(node_count)) + 1 levels.
// Reset clears only control state; no memory is cleared, so nodes must be loaded first.
// A finished result waits in the response register while rsp_stall is high.
`default_nettype none

module tree_lowest_common_ancestor_top
   import lca_pkg::*;
#(
   parameter int MAX_NODES   = MAX_NODES_DEF,
   parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [1:0]                      req_action,
   input  wire logic [$clog2(MAX_NODES)-1:0]    req_child_node,
   input  wire logic [$clog2(MAX_NODES)-1:0]    req_parent_node,
   input  wire logic [$clog2(MAX_NODES)-1:0]    req_node_a,
   input  wire logic [$clog2(MAX_NODES)-1:0]    req_node_b,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [$clog2(MAX_NODES)-1:0]    rsp_ancestor,
   output      logic                            rsp_bad_index,
   input  wire logic                            csr_we,
   input  wire logic [$clog2(MAX_NODES):0]      csr_wdata
);

   localparam int NW     = $clog2(MAX_NODES);
   localparam int CW     = NW + 1;
   localparam int LVW    = $clog2(LIFT_LEVELS);
   localparam int AW     = NW + LVW;
   localparam int TDEPTH = 1 << AW;

   function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] value);
      logic [CW-1:0] result;
      if (value == '0) begin
         result = CW'(1);
      end else if (value > CW'(MAX_NODES)) begin
         result = CW'(MAX_NODES);
      end else begin
         result = value;
      end
      return result;
   endfunction

   function automatic logic [LVW-1:0] top_of(input logic [CW-1:0] value);
      int highest;
      highest = 0;
      for (int k = 0; k < CW; k++) begin
         if (value[k]) begin
            highest = k;
         end
      end
      if (highest > LIFT_LEVELS - 1) begin
         highest = LIFT_LEVELS - 1;
      end
      return LVW'(highest);
   endfunction

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff;
   logic [LVW-1:0]  top_ff;
   logic [NW-1:0]   a_ff, a_in;
   logic [NW-1:0]   b_ff, b_in;
   logic [NW-1:0]   da_ff, da_in;
   logic [NW-1:0]   diff_ff, diff_in;
   logic [LVW-1:0]  lvl_ff, lvl_in;
   logic [NW-1:0]   res_ff, res_in;
   logic            bad_ff, bad_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]   rsp_ancestor_ff;
   logic            rsp_bad_ff;

   logic [NW-1:0]   tbl_mem [TDEPTH];
   logic [NW-1:0]   dep_mem [MAX_NODES];
   logic [NW-1:0]   tbl_rda_ff, tbl_rdb_ff, dep_rd_ff;
   logic            tbl_za_ff, tbl_zb_ff, dep_z_ff;
   logic [AW-1:0]   tbl_raa, tbl_rab, tbl_wa;
   logic [NW-1:0]   tbl_wd, dep_ra, dep_wa, dep_wd;
   logic            tbl_we, dep_we;

   logic [NW-1:0]   ua, ub, dep_val, dep_next;
   logic [NW:0]     step;
   logic            req_acc, rsp_load, load_ok, query_bad, lvl_zero, build_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ancestor  = rsp_ancestor_ff;
   assign rsp_bad_index = rsp_bad_ff;

   assign ua       = tbl_za_ff ? '0 : tbl_rda_ff;
   assign ub       = tbl_zb_ff ? '0 : tbl_rdb_ff;
   assign dep_val  = dep_z_ff ? '0 : dep_rd_ff;
   assign dep_next = (dep_val < NW'(MAX_NODES - 1)) ? dep_val + NW'(1) : dep_val;
   assign step     = (NW + 1)'(1) << lvl_ff;
   assign lvl_zero = (lvl_ff == '0);
   assign build_last = ({1'b0, a_ff} == cnt_ff - CW'(1));

   assign load_ok = (req_child_node != '0) && ({1'b0, req_child_node} < cnt_ff)
                 && ({1'b0, req_parent_node} < cnt_ff);
   assign query_bad = ({1'b0, req_node_a} >= cnt_ff) || ({1'b0, req_node_b} >= cnt_ff);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      tbl_rda_ff <= tbl_mem[tbl_raa];
      tbl_rdb_ff <= tbl_mem[tbl_rab];
      tbl_za_ff  <= (tbl_raa[AW-1:LVW] == '0);
      tbl_zb_ff  <= (tbl_rab[AW-1:LVW] == '0);
   end

   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_wa] <= dep_wd;
      end
      dep_rd_ff <= dep_mem[dep_ra];
      dep_z_ff  <= (dep_ra == '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (action_type'(req_action))
                  ACT_LOAD:  state_in = load_ok ? ST_LD_RD : ST_IDLE;
                  ACT_BUILD: state_in = (top_ff != '0) ? ST_BD_RD1 : ST_IDLE;
                  ACT_QUERY: state_in = query_bad ? ST_RESP : ST_QY_DA;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_RD:    state_in = ST_LD_WR;
         ST_LD_WR:    state_in = ST_IDLE;
         ST_BD_RD1:   state_in = ST_BD_RD2;
         ST_BD_RD2:   state_in = ST_BD_WR;
         ST_BD_WR: begin
            if (build_last && lvl_ff == top_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_BD_RD1;
            end
         end
         ST_QY_DA:    state_in = ST_QY_DB;
         ST_QY_DB:    state_in = ST_QY_SW;
         ST_QY_SW:    state_in = ST_QY_LIFT;
         ST_QY_LIFT: begin
            if ({1'b0, diff_ff} >= step) begin
               state_in = ST_QY_LIFTW;
            end else begin
               state_in = lvl_zero ? ST_QY_EQ : ST_QY_LIFT;
            end
         end
         ST_QY_LIFTW: state_in = lvl_zero ? ST_QY_EQ : ST_QY_LIFT;
         ST_QY_EQ:    state_in = (a_ff == b_ff) ? ST_RESP : ST_QY_PAR;
         ST_QY_PAR:   state_in = ST_QY_PARW;
         ST_QY_PARW:  state_in = lvl_zero ? ST_QY_FIN : ST_QY_PAR;
         ST_QY_FIN:   state_in = ST_QY_FINW;
         ST_QY_FINW:  state_in = ST_RESP;
         ST_RESP:     state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      da_in    = da_ff;
      diff_in  = diff_ff;
      lvl_in   = lvl_ff;
      res_in   = res_ff;
      bad_in   = bad_ff;
      tbl_raa  = {a_ff, lvl_ff};
      tbl_rab  = {b_ff, lvl_ff};
      tbl_we   = 1'b0;
      tbl_wa   = {a_ff, lvl_ff};
      tbl_wd   = ua;
      dep_ra   = a_ff;
      dep_we   = 1'b0;
      dep_wa   = a_ff;
      dep_wd   = dep_next;
      rsp_valid_in = (rsp_valid_ff && rsp_stall);
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (action_type'(req_action))
                  ACT_LOAD: begin
                     a_in = req_child_node;
                     b_in = req_parent_node;
                  end
                  ACT_BUILD: begin
                     a_in   = '0;
                     lvl_in = LVW'(1);
                  end
                  ACT_QUERY: begin
                     a_in   = req_node_a;
                     b_in   = req_node_b;
                     res_in = '0;
                     bad_in = query_bad;
                  end
                  default: begin
                     bad_in = bad_ff;
                  end
               endcase
            end
         end
         ST_LD_RD: begin
            dep_ra = b_ff;
         end
         ST_LD_WR: begin
            dep_we = 1'b1;
            tbl_we = 1'b1;
            tbl_wa = {a_ff, LVW'(0)};
            tbl_wd = b_ff;
         end
         ST_BD_RD1: begin
            tbl_raa = {a_ff, lvl_ff - LVW'(1)};
         end
         ST_BD_RD2: begin
            tbl_raa = {ua, lvl_ff - LVW'(1)};
         end
         ST_BD_WR: begin
            tbl_we = 1'b1;
            if (build_last) begin
               a_in   = '0;
               lvl_in = lvl_ff + LVW'(1);
            end else begin
               a_in = a_ff + NW'(1);
            end
         end
         ST_QY_DA: begin
            dep_ra = a_ff;
         end
         ST_QY_DB: begin
            dep_ra = b_ff;
            da_in  = dep_val;
         end
         ST_QY_SW: begin
            lvl_in = top_ff;
            if (da_ff < dep_val) begin
               a_in    = b_ff;
               b_in    = a_ff;
               diff_in = dep_val - da_ff;
            end else begin
               diff_in = da_ff - dep_val;
            end
         end
         ST_QY_LIFT: begin
            if (({1'b0, diff_ff} < step) && !lvl_zero) begin
               lvl_in = lvl_ff - LVW'(1);
            end
         end
         ST_QY_LIFTW: begin
            a_in    = ua;
            diff_in = diff_ff - step[NW-1:0];
            if (!lvl_zero) begin
               lvl_in = lvl_ff - LVW'(1);
            end
         end
         ST_QY_EQ: begin
            lvl_in = top_ff;
            res_in = a_ff;
         end
         ST_QY_PARW: begin
            if (ua != ub) begin
               a_in = ua;
               b_in = ub;
            end
            if (!lvl_zero) begin
               lvl_in = lvl_ff - LVW'(1);
            end
         end
         ST_QY_FIN: begin
            tbl_raa = {a_ff, LVW'(0)};
         end
         ST_QY_FINW: begin
            res_in = ua;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= CW'(1);
         top_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cnt_ff <= clamp_count(csr_wdata);
            top_ff <= top_of(clamp_count(csr_wdata));
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      da_ff   <= da_in;
      diff_ff <= diff_in;
      lvl_ff  <= lvl_in;
      res_ff  <= res_in;
      bad_ff  <= bad_in;
      if (state_ff == ST_RESP && rsp_load) begin
         rsp_ancestor_ff <= res_ff;
         rsp_bad_ff      <= bad_ff;
      end
   end

endmodule

`default_nettype wire

>>> src/lca_checker.sv
// Port-level checks for the lowest common ancestor block, bound to its top level.
// Depends on lca_pkg and tree_lowest_common_ancestor_top.
`default_nettype none

module lca_port_checker
   import lca_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic [1:0]                    req_action,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [$clog2(MAX_NODES)-1:0]  rsp_ancestor,
   input wire logic                          rsp_bad_index
);

   // A rejected query always reports the root as its answer.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_index) |-> (rsp_ancestor == '0))
      else $error("bad index transaction with non-zero ancestor");

   // Every query keeps the block busy for at least the following cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACT_QUERY) |=> req_stall)
      else $error("request accepted directly after a query");

   // No response is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ancestor)
                                    && $stable(rsp_bad_index)))
      else $error("stalled response transaction changed");

endmodule

bind tree_lowest_common_ancestor_top lca_port_checker #(
   .MAX_NODES(MAX_NODES)
) u_lca_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_ancestor  (rsp_ancestor),
   .rsp_bad_index (rsp_bad_index)
);

`default_nettype wire

>>> sim/lca_checker.sv
// Checker for the lowest common ancestor block: watches the request, response and csr ports,
// predicts each query answer from its own copy of the tree and compares it field by field.
// Depends on lca_pkg.
module lca_checker
   import lca_pkg::*;
#(
   parameter int NODE_W = $clog2(MAX_NODES_DEF)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [1:0]        req_action,
   input  wire logic [NODE_W-1:0] req_child_node,
   input  wire logic [NODE_W-1:0] req_parent_node,
   input  wire logic [NODE_W-1:0] req_node_a,
   input  wire logic [NODE_W-1:0] req_node_b,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [NODE_W-1:0] rsp_ancestor,
   input  wire logic              rsp_bad_index,
   input  wire logic              csr_we,
   input  wire logic [NODE_W:0]   csr_wdata,
   output int                     failures,
   output int                     pending
);

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic              bad_index;
   } lca_answer_type;

   logic [NODE_W-1:0] up_table   [MAX_NODES_DEF][LIFT_LEVELS_DEF];
   logic [NODE_W-1:0] node_level [MAX_NODES_DEF];
   logic [NODE_W:0]   count_reg;
   lca_answer_type    answers_due [$];

   function automatic int nodes_in_use();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_NODES_DEF) return MAX_NODES_DEF;
      return int'(count_reg);
   endfunction

   function automatic int top_lift_level();
      int span;
      int lv;
      span = nodes_in_use();
      lv   = 0;
      while (span > 1) begin
         span = span >> 1;
         lv++;
      end
      if (lv > LIFT_LEVELS_DEF - 1) lv = LIFT_LEVELS_DEF - 1;
      return lv;
   endfunction

   function automatic void record_parent(input logic [NODE_W-1:0] child,
                                         input logic [NODE_W-1:0] parent);
      int n;
      n = nodes_in_use();
      if (child == 0 || child >= n || parent >= n) return;
      up_table[child][0] = parent;
      if (node_level[parent] == MAX_NODES_DEF - 1) node_level[child] = node_level[parent];
      else node_level[child] = node_level[parent] + 1'b1;
   endfunction

   function automatic void fill_lift_table();
      int n;
      int top;
      n   = nodes_in_use();
      top = top_lift_level();
      for (int lv = 1; lv <= top; lv++) begin
         for (int j = 0; j < n; j++) begin
            up_table[j][lv] = up_table[up_table[j][lv-1]][lv-1];
         end
      end
   endfunction

   function automatic logic [NODE_W-1:0] common_ancestor(input logic [NODE_W-1:0] a,
                                                          input logic [NODE_W-1:0] b);
      logic [NODE_W-1:0] x;
      logic [NODE_W-1:0] y;
      logic [NODE_W-1:0] ux;
      logic [NODE_W-1:0] uy;
      int gap;
      int top;
      top = top_lift_level();
      x   = a;
      y   = b;
      if (node_level[x] < node_level[y]) begin
         x = b;
         y = a;
      end
      gap = int'(node_level[x]) - int'(node_level[y]);
      for (int lv = top; lv >= 0; lv--) begin
         if (gap >= (1 << lv)) begin
            gap = gap - (1 << lv);
            x   = up_table[x][lv];
         end
      end
      if (x == y) return x;
      for (int lv = top; lv >= 0; lv--) begin
         ux = up_table[x][lv];
         uy = up_table[y][lv];
         if (ux != uy) begin
            x = ux;
            y = uy;
         end
      end
      return up_table[x][0];
   endfunction

   always @(posedge clock) begin
      lca_answer_type want;
      int n;
      if (reset) begin
         foreach (up_table[i, j]) up_table[i][j] = '0;
         foreach (node_level[i]) node_level[i] = '0;
         count_reg = (NODE_W + 1)'(1);
         answers_due.delete();
         failures = 0;
      end else begin
         if (csr_we) count_reg = csr_wdata;
         if (req_valid && !req_stall) begin
            case (req_action)
               ACT_LOAD: begin
                  record_parent(req_child_node, req_parent_node);
               end
               ACT_BUILD: begin
                  fill_lift_table();
               end
               ACT_QUERY: begin
                  n = nodes_in_use();
                  if (req_node_a >= n || req_node_b >= n) begin
                     want.ancestor  = '0;
                     want.bad_index = 1'b1;
                  end else begin
                     want.ancestor  = common_ancestor(req_node_a, req_node_b);
                     want.bad_index = 1'b0;
                  end
                  answers_due.push_back(want);
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response, ancestor %0d bad_index %0d",
                        $time, rsp_ancestor, rsp_bad_index);
               failures++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_ancestor !== want.ancestor) begin
                  $display("%0t: ancestor expected %0d actual %0d",
                           $time, want.ancestor, rsp_ancestor);
                  failures++;
               end
               if (rsp_bad_index !== want.bad_index) begin
                  $display("%0t: bad_index expected %0d actual %0d",
                           $time, want.bad_index, rsp_bad_index);
                  failures++;
               end
            end
         end
      end
      pending = answers_due.size();
   end

endmodule

>>> sim/tb_top.sv
// Top of the lowest common ancestor testbench: clock, reset, csr writes and request stimulus,
// with random idling on both channels. Depends on lca_pkg, lca_checker and
// tree_lowest_common_ancestor_top.
module tb_top;
   import lca_pkg::*;

   localparam int         NODE_W        = $clog2(MAX_NODES_DEF);
   localparam int         CYCLE_LIMIT   = 4_000_000;
   localparam int         SETTLE_CYCLES = 64;
   localparam logic [1:0] ACT_SPARE     = 2'd3;
   localparam int         TREE_KEEP     = 0;
   localparam int         TREE_RANDOM   = 1;
   localparam int         TREE_CHAIN    = 2;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_action;
   logic [NODE_W-1:0] req_child_node;
   logic [NODE_W-1:0] req_parent_node;
   logic [NODE_W-1:0] req_node_a;
   logic [NODE_W-1:0] req_node_b;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [NODE_W-1:0] rsp_ancestor;
   logic              rsp_bad_index;
   logic              csr_we;
   logic [NODE_W:0]   csr_wdata;
   int                failures;
   int                pending;
   int                item_count = 0;
   int                cycles     = 0;
   logic              calm;

   assign calm = (item_count >= 1100 && item_count < 1400);

   tree_lowest_common_ancestor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_child_node  (req_child_node),
      .req_parent_node (req_parent_node),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_bad_index   (rsp_bad_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   lca_checker ancestor_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_child_node  (req_child_node),
      .req_parent_node (req_parent_node),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_bad_index   (rsp_bad_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 15);
   end

   function automatic logic [NODE_W-1:0] rnd_node();
      return NODE_W'($urandom_range(0, MAX_NODES_DEF - 1));
   endfunction

   function automatic int usable_nodes(input logic [NODE_W:0] value);
      if (value == 0) return 1;
      if (value > MAX_NODES_DEF) return MAX_NODES_DEF;
      return int'(value);
   endfunction

   task automatic send_item(input logic [1:0] act, input logic [NODE_W-1:0] child,
                            input logic [NODE_W-1:0] parent,
                            input logic [NODE_W-1:0] node_a,
                            input logic [NODE_W-1:0] node_b);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_child_node  <= child;
      req_parent_node <= parent;
      req_node_a      <= node_a;
      req_node_b      <= node_b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_node_count(input logic [NODE_W:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_item(input int n);
      int unsigned       roll;
      logic [1:0]        act;
      logic [NODE_W-1:0] c;
      logic [NODE_W-1:0] p;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [NODE_W-1:0] t;
      roll = $urandom_range(0, 99);
      c    = rnd_node();
      p    = rnd_node();
      a    = rnd_node();
      b    = rnd_node();
      act  = ACT_QUERY;
      if (roll < 55) begin
         a = NODE_W'($urandom_range(0, n - 1));
         b = NODE_W'($urandom_range(0, n - 1));
         if ($urandom_range(0, 9) == 0) a = NODE_W'(n - 1);
      end else if (roll < 65) begin
         if (n < MAX_NODES_DEF) begin
            a = NODE_W'($urandom_range(n, MAX_NODES_DEF - 1));
            if ($urandom_range(0, 1) == 1) begin
               t = a;
               a = b;
               b = t;
            end
         end
      end else if (roll < 80) begin
         act = ACT_LOAD;
         if (n > 1) begin
            c = NODE_W'($urandom_range(1, n - 1));
            p = NODE_W'($urandom_range(0, n - 1));
         end else begin
            c = '0;
         end
      end else if (roll < 85) begin
         act = ACT_LOAD;
         if (n == MAX_NODES_DEF || $urandom_range(0, 2) == 0) begin
            c = '0;
         end else if ($urandom_range(0, 1) == 1) begin
            c = NODE_W'($urandom_range(n, MAX_NODES_DEF - 1));
         end else begin
            c = NODE_W'($urandom_range(0, n - 1));
            p = NODE_W'($urandom_range(n, MAX_NODES_DEF - 1));
         end
      end else if (roll < 90) begin
         if (n < 512 || $urandom_range(0, 3) == 0) act = ACT_BUILD;
      end else if (roll < 95) begin
         act = ACT_SPARE;
      end else begin
         act = 2'($urandom_range(0, 3));
      end
      send_item(act, c, p, a, b);
   endtask

   task automatic run_phase(input int value, input int shape, input int count);
      int              n;
      logic [NODE_W:0] count_value;
      count_value = (NODE_W + 1)'(value);
      set_node_count(count_value);
      n = usable_nodes(count_value);
      if (shape != TREE_KEEP) begin
         for (int k = 1; k < n; k++) begin
            if (shape == TREE_CHAIN || $urandom_range(0, 9) < 4)
               send_item(ACT_LOAD, NODE_W'(k), NODE_W'(k - 1), rnd_node(), rnd_node());
            else
               send_item(ACT_LOAD, NODE_W'(k), NODE_W'($urandom_range(0, k - 1)),
                         rnd_node(), rnd_node());
         end
      end
      send_item(ACT_BUILD, rnd_node(), rnd_node(), rnd_node(), rnd_node());
      repeat (count) random_item(n);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), NODE_W'($urandom_range(0, n - 1)),
                NODE_W'($urandom_range(0, n - 1)));
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_LOAD;
      req_child_node  = '0;
      req_parent_node = '0;
      req_node_a      = '0;
      req_node_b      = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset node count only the root is in use, so every other index is bad.
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '0, '0);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '0, NODE_W'(1));
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '1, '1);
      send_item(ACT_LOAD, '0, '0, rnd_node(), rnd_node());
      send_item(ACT_LOAD, NODE_W'(1), '0, rnd_node(), rnd_node());
      send_item(ACT_SPARE, rnd_node(), rnd_node(), rnd_node(), rnd_node());
      send_item(ACT_BUILD, rnd_node(), rnd_node(), rnd_node(), rnd_node());
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '0, '0);

      // A full chain reaches the deepest possible node and gives every node but the root a parent.
      run_phase(MAX_NODES_DEF, TREE_CHAIN, 0);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '1, '0);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '1, NODE_W'(512));
      send_item(ACT_QUERY, rnd_node(), rnd_node(), '1, '1);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), NODE_W'(300), NODE_W'(700));
      // Hanging node 1 below the deepest node makes its depth saturate.
      send_item(ACT_LOAD, NODE_W'(1), '1, rnd_node(), rnd_node());
      send_item(ACT_QUERY, rnd_node(), rnd_node(), NODE_W'(1), NODE_W'(2));
      send_item(ACT_QUERY, rnd_node(), rnd_node(), NODE_W'(1), '1);
      send_item(ACT_LOAD, '0, NODE_W'(5), rnd_node(), rnd_node());
      repeat (40) random_item(MAX_NODES_DEF);
      send_item(ACT_QUERY, rnd_node(), rnd_node(), rnd_node(), rnd_node());

      run_phase(2, TREE_RANDOM, 40);
      run_phase(3, TREE_RANDOM, 40);
      run_phase(0, TREE_KEEP, 30);
      run_phase(17, TREE_RANDOM, 80);
      run_phase(2047, TREE_KEEP, 60);
      run_phase(100, TREE_RANDOM, 110);
      run_phase(64, TREE_RANDOM, 100);
      run_phase(1023, TREE_KEEP, 80);
      run_phase(1, TREE_KEEP, 20);
      run_phase(300, TREE_KEEP, 120);

      drain_results();
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
src/lca_pkg.sv
src/tree_lowest_common_ancestor_top.sv
src/lca_checker.sv
sim/lca_checker.sv
sim/tb_top.sv
